// ===== rtl/tgad_pkg.sv =====
// ----------------------------------------------------------------------------
// tgad_pkg
// Shared types and constants for the TGA image stream decoder.
// ----------------------------------------------------------------------------
package tgad_pkg;

  localparam int TGAD_PIXEL_INDEX_BITS = 24;
  localparam int TGAD_HEADER_BYTES     = 18;

  localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
  localparam logic [7:0] TYPE_GRAY      = 8'd3;
  localparam logic [7:0] TYPE_RLE_TRUE  = 8'd10;

  localparam logic [7:0] DEPTH_8  = 8'd8;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] RUN_FLAG     = 8'h80;
  localparam logic [7:0] COUNT_MASK   = 8'h7f;
  localparam logic [7:0] TOP_DOWN_BIT = 8'h20;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SHORT     = 3'd1,
    ERR_TYPE      = 3'd2,
    ERR_COLORMAP  = 3'd3,
    ERR_DEPTH     = 3'd4,
    ERR_SIZE      = 3'd5,
    ERR_TRUNCATED = 3'd6
  } err_t;

  typedef struct packed {
    logic [7:0]  img_type;
    logic [7:0]  cmap_type;
    logic [7:0]  depth;
    logic [31:0] area;
  } hdr_info_t;

endpackage

// ===== rtl/tgad_hdr_check.sv =====
// ----------------------------------------------------------------------------
// tgad_hdr_check
// Validates the gathered header fields and returns the first error found.
// ----------------------------------------------------------------------------
module tgad_hdr_check
  import tgad_pkg::*;
#(
  parameter int PIXEL_INDEX_BITS = TGAD_PIXEL_INDEX_BITS
) (
  input  hdr_info_t hdr,
  output err_t      err
);

  logic type_ok;
  logic depth_ok;
  logic size_ok;

  always_comb begin
    type_ok  = (hdr.img_type == TYPE_TRUECOLOR) || (hdr.img_type == TYPE_GRAY) ||
               (hdr.img_type == TYPE_RLE_TRUE);
    depth_ok = (hdr.depth == DEPTH_24) || (hdr.depth == DEPTH_32) ||
               ((hdr.depth == DEPTH_8) && (hdr.img_type == TYPE_GRAY));
    size_ok  = (hdr.area != 32'd0) && (hdr.area[31:PIXEL_INDEX_BITS] == '0) &&
               (hdr.area[31:29] == 3'd0);
    if (!type_ok) begin
      err = ERR_TYPE;
    end else if (hdr.cmap_type != 8'd0) begin
      err = ERR_COLORMAP;
    end else if (!depth_ok) begin
      err = ERR_DEPTH;
    end else if (!size_ok) begin
      err = ERR_SIZE;
    end else begin
      err = ERR_NONE;
    end
  end

endmodule

// ===== rtl/tgad_skid.sv =====
// ----------------------------------------------------------------------------
// tgad_skid
// Two-entry output buffer that decouples the decoder from the result stall.
// ----------------------------------------------------------------------------
module tgad_skid
  import tgad_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_data
);

  logic             main_valid;
  logic [WIDTH-1:0] main_data;
  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             push;
  logic             take;

  assign in_stall  = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign push      = in_valid && !skid_valid;
  assign take      = main_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!main_valid || take) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!main_valid || take) begin
        main_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end else if (take && skid_valid) begin
      main_data <= skid_data;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> !skid_valid)
    else $error("skid entry not drained after a transfer");

  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (push && main_valid && out_stall) |=> skid_valid)
    else $error("result lost while output register was stalled");

endmodule

// ===== rtl/tga_image_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_image_stream_decoder
// Parses a truecolor or grayscale TGA byte stream and emits RGBA pixel runs.
//
//   Channel   Handshake                 Payload
//   input     data_valid / data_stall   data_byte, last_byte
//   output    pixel_valid / pixel_stall red, green, blue, alpha, pixel_index,
//                                       repeat_count, top_down, image_done,
//                                       error_code
//
// One byte is taken per cycle unless stalled; each result is registered.
// Image area is multiplied on header byte 16 and checked on byte 17.
// Reset returns the parser to the start of a header; no clearing pass.
// Input stalls only when both entries of the output buffer are full.
// ----------------------------------------------------------------------------
module tga_image_stream_decoder
  import tgad_pkg::*;
#(
  parameter int PIXEL_INDEX_BITS = TGAD_PIXEL_INDEX_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        data_valid,
  output logic                        data_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  output logic                        pixel_valid,
  input  logic                        pixel_stall,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic [7:0]                  alpha,
  output logic [PIXEL_INDEX_BITS-1:0] pixel_index,
  output logic [7:0]                  repeat_count,
  output logic                        top_down,
  output logic                        image_done,
  output logic [2:0]                  error_code
);

  localparam int PIB     = PIXEL_INDEX_BITS;
  localparam int RES_W   = 4 * 8 + PIB + 8 + 1 + 1 + 3;
  localparam int LAST_HB = TGAD_HEADER_BYTES - 1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_IDSKIP,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  phase_t          phase, phase_next;
  logic [4:0]      hcount, hcount_next;
  logic [7:0]      id_left, id_left_next;
  logic [7:0]      hdr_cmap, hdr_cmap_next;
  logic [7:0]      hdr_type, hdr_type_next;
  logic [7:0]      hdr_depth, hdr_depth_next;
  logic [15:0]     width, width_next;
  logic [15:0]     height, height_next;
  logic [31:0]     area, area_next;
  logic            top_down_flag, top_down_flag_next;
  logic            is_rle, is_rle_next;
  logic [1:0]      pix_last, pix_last_next;
  logic [PIB-1:0]  pixels_left, pixels_left_next;
  logic [PIB-1:0]  next_pixel, next_pixel_next;
  logic [7:0]      packet_left, packet_left_next;
  logic            packet_is_run, packet_is_run_next;
  logic [1:0]      byte_in_pixel, byte_in_pixel_next;
  logic [23:0]     pix_bytes, pix_bytes_next;

  logic            accept;
  hdr_info_t       hdr;
  err_t            hdr_err;
  logic [2:0]      bytes_per_pixel;
  logic [7:0]      rep;
  logic            clip;
  logic [PIB-1:0]  rep_clipped;

  logic            res_valid;
  logic [7:0]      res_red, res_green, res_blue, res_alpha;
  logic [PIB-1:0]  res_index;
  logic [7:0]      res_repeat;
  logic            res_done;
  err_t            res_err;
  logic [RES_W-1:0] res_data;
  logic [RES_W-1:0] out_data;

  assign accept = data_valid && !data_stall;

  assign hdr.img_type  = hdr_type;
  assign hdr.cmap_type = hdr_cmap;
  assign hdr.depth     = hdr_depth;
  assign hdr.area      = area;

  tgad_hdr_check #(
    .PIXEL_INDEX_BITS(PIB)
  ) u_hdr_check (
    .hdr(hdr),
    .err(hdr_err)
  );

  assign bytes_per_pixel = hdr_depth[5:3];
  assign rep             = packet_is_run ? packet_left : 8'd1;
  assign clip            = pixels_left <= PIB'(rep);
  assign rep_clipped     = clip ? pixels_left : PIB'(rep);

  always_comb begin
    phase_next         = phase;
    hcount_next        = hcount;
    id_left_next       = id_left;
    hdr_cmap_next      = hdr_cmap;
    hdr_type_next      = hdr_type;
    hdr_depth_next     = hdr_depth;
    width_next         = width;
    height_next        = height;
    area_next          = area;
    top_down_flag_next = top_down_flag;
    is_rle_next        = is_rle;
    pix_last_next      = pix_last;
    pixels_left_next   = pixels_left;
    next_pixel_next    = next_pixel;
    packet_left_next   = packet_left;
    packet_is_run_next = packet_is_run;
    byte_in_pixel_next = byte_in_pixel;
    pix_bytes_next     = pix_bytes;

    res_valid  = 1'b0;
    res_red    = 8'd0;
    res_green  = 8'd0;
    res_blue   = 8'd0;
    res_alpha  = 8'd0;
    res_index  = '0;
    res_repeat = 8'd0;
    res_done   = 1'b0;
    res_err    = ERR_NONE;

    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          unique case (hcount)
            5'd0:  id_left_next        = data_byte;
            5'd1:  hdr_cmap_next       = data_byte;
            5'd2:  hdr_type_next       = data_byte;
            5'd12: width_next[7:0]     = data_byte;
            5'd13: width_next[15:8]    = data_byte;
            5'd14: height_next[7:0]    = data_byte;
            5'd15: height_next[15:8]   = data_byte;
            5'd16: begin
              hdr_depth_next = data_byte;
              area_next      = 32'(width) * 32'(height);
            end
            5'd17: top_down_flag_next = (data_byte & TOP_DOWN_BIT) != 8'd0;
            default: ;
          endcase
          if (hcount != 5'(LAST_HB)) begin
            hcount_next = hcount + 5'd1;
            if (last_byte) begin
              res_valid  = 1'b1;
              res_err    = ERR_SHORT;
              phase_next = PH_DONE;
            end
          end else begin
            hcount_next = 5'd0;
            if (hdr_err != ERR_NONE) begin
              res_valid  = 1'b1;
              res_err    = hdr_err;
              phase_next = PH_DONE;
            end else begin
              is_rle_next        = hdr_type == TYPE_RLE_TRUE;
              pix_last_next      = 2'(bytes_per_pixel - 3'd1);
              pixels_left_next   = area[PIB-1:0];
              next_pixel_next    = '0;
              packet_left_next   = 8'd0;
              packet_is_run_next = 1'b0;
              byte_in_pixel_next = 2'd0;
              pix_bytes_next     = 24'd0;
              phase_next         = (id_left != 8'd0) ? PH_IDSKIP : PH_PIXELS;
              if (last_byte) begin
                res_valid  = 1'b1;
                res_err    = (id_left != 8'd0) ? ERR_SHORT : ERR_TRUNCATED;
                phase_next = PH_DONE;
              end
            end
          end
        end
        PH_IDSKIP: begin
          id_left_next = id_left - 8'd1;
          if (id_left_next == 8'd0) begin
            phase_next = PH_PIXELS;
          end
          if (last_byte) begin
            res_valid  = 1'b1;
            res_err    = (id_left_next != 8'd0) ? ERR_SHORT : ERR_TRUNCATED;
            phase_next = PH_DONE;
          end
        end
        PH_PIXELS: begin
          if (is_rle && packet_left == 8'd0) begin
            packet_left_next   = (data_byte & COUNT_MASK) + 8'd1;
            packet_is_run_next = (data_byte & RUN_FLAG) != 8'd0;
            byte_in_pixel_next = 2'd0;
            pix_bytes_next     = 24'd0;
            if (last_byte) begin
              res_valid  = 1'b1;
              res_err    = ERR_TRUNCATED;
              phase_next = PH_DONE;
            end
          end else if (byte_in_pixel != pix_last) begin
            case (byte_in_pixel)
              2'd0:    pix_bytes_next[7:0]   = data_byte;
              2'd1:    pix_bytes_next[15:8]  = data_byte;
              default: pix_bytes_next[23:16] = data_byte;
            endcase
            byte_in_pixel_next = byte_in_pixel + 2'd1;
            if (last_byte) begin
              res_valid  = 1'b1;
              res_err    = ERR_TRUNCATED;
              phase_next = PH_DONE;
            end
          end else begin
            byte_in_pixel_next = 2'd0;
            pix_bytes_next     = 24'd0;
            if (is_rle) begin
              packet_left_next = packet_is_run ? 8'd0 : packet_left - 8'd1;
            end
            next_pixel_next  = next_pixel + rep_clipped;
            pixels_left_next = pixels_left - rep_clipped;
            res_valid        = 1'b1;
            if (!clip && last_byte) begin
              res_err    = ERR_TRUNCATED;
              phase_next = PH_DONE;
            end else begin
              case (pix_last)
                2'd0: begin
                  res_red   = data_byte;
                  res_green = data_byte;
                  res_blue  = data_byte;
                  res_alpha = ALPHA_OPAQUE;
                end
                2'd2: begin
                  res_blue  = pix_bytes[7:0];
                  res_green = pix_bytes[15:8];
                  res_red   = data_byte;
                  res_alpha = ALPHA_OPAQUE;
                end
                default: begin
                  res_blue  = pix_bytes[7:0];
                  res_green = pix_bytes[15:8];
                  res_red   = pix_bytes[23:16];
                  res_alpha = data_byte;
                end
              endcase
              res_index  = next_pixel;
              res_repeat = rep_clipped[7:0];
              res_done   = clip;
              if (clip) begin
                phase_next = PH_DONE;
              end
            end
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      hcount        <= 5'd0;
      id_left       <= 8'd0;
      hdr_cmap      <= 8'd0;
      hdr_type      <= 8'd0;
      hdr_depth     <= 8'd0;
      width         <= 16'd0;
      height        <= 16'd0;
      area          <= 32'd0;
      top_down_flag <= 1'b0;
      is_rle        <= 1'b0;
      pix_last      <= 2'd0;
      pixels_left   <= '0;
      next_pixel    <= '0;
      packet_left   <= 8'd0;
      packet_is_run <= 1'b0;
      byte_in_pixel <= 2'd0;
      pix_bytes     <= 24'd0;
    end else begin
      phase         <= phase_next;
      hcount        <= hcount_next;
      id_left       <= id_left_next;
      hdr_cmap      <= hdr_cmap_next;
      hdr_type      <= hdr_type_next;
      hdr_depth     <= hdr_depth_next;
      width         <= width_next;
      height        <= height_next;
      area          <= area_next;
      top_down_flag <= top_down_flag_next;
      is_rle        <= is_rle_next;
      pix_last      <= pix_last_next;
      pixels_left   <= pixels_left_next;
      next_pixel    <= next_pixel_next;
      packet_left   <= packet_left_next;
      packet_is_run <= packet_is_run_next;
      byte_in_pixel <= byte_in_pixel_next;
      pix_bytes     <= pix_bytes_next;
    end
  end

  assign res_data = {res_red, res_green, res_blue, res_alpha, res_index, res_repeat,
                     top_down_flag_next, res_done, res_err};

  tgad_skid #(
    .WIDTH(RES_W)
  ) u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_stall (data_stall),
    .in_data  (res_data),
    .out_valid(pixel_valid),
    .out_stall(pixel_stall),
    .out_data (out_data)
  );

  assign {red, green, blue, alpha, pixel_index, repeat_count,
          top_down, image_done, error_code} = out_data;

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |=> (phase == PH_DONE))
    else $error("decoder left the finished state without reset");

endmodule
